### src/gb3_pkg.sv
`timescale 1ns / 1ps

package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_WIDTH  = 3;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = CFG_W'(1024);

  // floor(n / 100) == (n * DIV_RECIP) >> DIV_SHIFT for every n below 2^15
  localparam int              NUM_W     = 15;
  localparam int              PROD_W    = 2 * NUM_W;
  localparam int              DIV_SHIFT = 21;
  localparam logic [NUM_W-1:0] DIV_RECIP = NUM_W'(20972);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
  } out_t;

  // Two previous window columns: [0..2] oldest (top, mid, bottom), [3..5] next.
  typedef logic [5:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } ls_wr_t;

endpackage

### src/gb3_line_store.sv
`timescale 1ns / 1ps

module gb3_line_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [gb3_pkg::COL_W-1:0]   rd_addr_i,
  input  gb3_pkg::ls_wr_t             wr_i,
  output logic [gb3_pkg::PIX_W-1:0]   upper_o,
  output logic [gb3_pkg::PIX_W-1:0]   middle_o
);

  // Upper and middle rows share one address, so they live in one wide memory.
  logic [2*gb3_pkg::PIX_W-1:0] mem [gb3_pkg::MAX_WIDTH];
  logic [2*gb3_pkg::PIX_W-1:0] rd_q;
  logic [2*gb3_pkg::PIX_W-1:0] fwd_q;
  logic                        hit_q;
  logic                        hit_d;

  assign hit_d = wr_i.en && (wr_i.addr == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.upper, wr_i.middle};
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= {wr_i.upper, wr_i.middle};
    end
  end

  // Read and write at the same address in one cycle: hand over the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= hit_d;
    end
  end

  assign {upper_o, middle_o} = hit_q ? fwd_q : rd_q;

endmodule

### src/gb3_kernel.sv
`timescale 1ns / 1ps

module gb3_kernel (
  input  gb3_pkg::win_t               win_i,
  input  logic [gb3_pkg::PIX_W-1:0]   upper_i,
  input  logic [gb3_pkg::PIX_W-1:0]   middle_i,
  input  logic [gb3_pkg::PIX_W-1:0]   pixel_i,
  output logic [gb3_pkg::PIX_W-1:0]   blurred_o
);

  logic [9:0]                    corners;
  logic [10:0]                   others;
  logic [gb3_pkg::NUM_W-1:0]     num;
  logic [gb3_pkg::PROD_W-1:0]    prod;

  assign corners = {2'b0, win_i[0]} + {2'b0, win_i[2]} + {2'b0, upper_i} + {2'b0, pixel_i};
  assign others  = {3'b0, win_i[1]} + {3'b0, win_i[3]} + {3'b0, win_i[4]}
                 + {3'b0, win_i[5]} + {3'b0, middle_i};

  assign num = ({5'b0, corners} * gb3_pkg::NUM_W'(9))
             + ({4'b0, others} * gb3_pkg::NUM_W'(12));

  // divide by 100 through the reciprocal
  assign prod = {{gb3_pkg::NUM_W{1'b0}}, num}
              * {{gb3_pkg::NUM_W{1'b0}}, gb3_pkg::DIV_RECIP};

  assign blurred_o = prod[gb3_pkg::DIV_SHIFT +: gb3_pkg::PIX_W];

endmodule

### src/gaussian_blur_3x3_stream.sv
`timescale 1ns / 1ps
// 3x3 blur over a raster pixel stream, one pixel accepted per clock.
// A result goes from its pixel transaction through the registered line-store
// read and the result register.
// Throughput: 1 pixel per cycle; only output stall holds the input back.
// Reset clears position counters, window, valid flags and line_width (1024);
// line-store contents stay undefined until written, with no clearing pass.

module gaussian_blur_3x3_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gb3_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gb3_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [gb3_pkg::CFG_W-1:0]   cfg_wdata_i
);

  logic [gb3_pkg::CFG_W-1:0] line_width_q;
  logic [gb3_pkg::CFG_W-1:0] eff_width;

  logic [gb3_pkg::COL_W-1:0] col_q, col_d, col_cur;
  logic [gb3_pkg::ROW_W-1:0] row_q, row_d, row_cur;
  logic                      wrap;

  logic                      in_fire;
  logic                      s1_fire;

  logic                      s1_valid_q;
  logic                      s1_res_q;
  logic [gb3_pkg::PIX_W-1:0] s1_pix_q;
  logic [gb3_pkg::COL_W-1:0] s1_col_q;
  logic [gb3_pkg::ROW_W-1:0] s1_row_q;

  gb3_pkg::win_t             win_q;
  gb3_pkg::ls_wr_t           ls_wr;
  logic [gb3_pkg::PIX_W-1:0] ls_upper;
  logic [gb3_pkg::PIX_W-1:0] ls_middle;
  logic [gb3_pkg::PIX_W-1:0] blurred;

  logic                      out_valid_q;
  gb3_pkg::out_t             out_q;

  always_comb begin
    eff_width = line_width_q;
    if (line_width_q < gb3_pkg::CFG_W'(gb3_pkg::MIN_WIDTH)) begin
      eff_width = gb3_pkg::CFG_W'(gb3_pkg::MIN_WIDTH);
    end else if (line_width_q > gb3_pkg::CFG_W'(gb3_pkg::MAX_WIDTH)) begin
      eff_width = gb3_pkg::CFG_W'(gb3_pkg::MAX_WIDTH);
    end
  end

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // position of the incoming pixel; frame start forces row 0, column 0
  assign col_cur = in_data_i.frame_start ? '0 : col_q;
  assign row_cur = in_data_i.frame_start ? '0 : row_q;
  assign wrap    = ({1'b0, col_cur} + gb3_pkg::CFG_W'(1)) >= eff_width;

  always_comb begin
    col_d = col_cur + gb3_pkg::COL_W'(1);
    row_d = row_cur;
    if (wrap) begin
      col_d = '0;
      if (row_cur < gb3_pkg::ROW_W'(gb3_pkg::MAX_HEIGHT - 1)) begin
        row_d = row_cur + gb3_pkg::ROW_W'(1);
      end
    end
  end

  assign ls_wr.en     = s1_fire;
  assign ls_wr.addr   = s1_col_q;
  assign ls_wr.upper  = ls_middle;
  assign ls_wr.middle = s1_pix_q;

  gb3_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_cur),
    .wr_i      (ls_wr),
    .upper_o   (ls_upper),
    .middle_o  (ls_middle)
  );

  gb3_kernel u_kernel (
    .win_i     (win_q),
    .upper_i   (ls_upper),
    .middle_i  (ls_middle),
    .pixel_i   (s1_pix_q),
    .blurred_o (blurred)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= gb3_pkg::LINE_WIDTH_RESET;
      col_q        <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      s1_res_q     <= 1'b0;
      win_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        col_q    <= col_d;
        row_q    <= row_d;
        s1_res_q <= (row_cur >= gb3_pkg::ROW_W'(2)) && (col_cur >= gb3_pkg::COL_W'(2));
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        win_q <= {s1_pix_q, ls_middle, ls_upper, win_q[5], win_q[4], win_q[3]};
      end
      if (s1_fire) begin
        out_valid_q <= s1_res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= in_data_i.pixel;
      s1_col_q <= col_cur;
      s1_row_q <= row_cur;
    end
    if (s1_fire) begin
      out_q.blurred <= blurred;
      out_q.out_row <= s1_row_q - gb3_pkg::ROW_W'(1);
      out_q.out_col <= s1_col_q - gb3_pkg::COL_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/gb3_checker.sv
`timescale 1ns / 1ps

module gb3_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input gb3_pkg::out_t             out_data_o
);

  // a pending result stays offered while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input is only held back by a stalled, full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // weights sum to 96/100, so a full-white window gives at most 244
  a_blur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.blurred <= 8'd244)
    else $error("blurred value out of range");

  // window centre never lies on the top row or left column
  a_no_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_row != '0) && (out_data_o.out_col != '0))
    else $error("result reported for a border pixel");

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DIR_N      = 25;
  localparam int RAND_ITEMS = 1200;
  localparam int HOLD_AT    = 200;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [gb3_pkg::PIX_W-1:0] pixel;
    logic                      fs;
    logic                      typed;
    logic [gb3_pkg::PIX_W-1:0] blurred;
    logic [gb3_pkg::ROW_W-1:0] row;
    logic [gb3_pkg::COL_W-1:0] col;
  } dir_row_t;

  // Width 3 throughout: all-white frame, all-black frame, then mixed rows
  // with a frame start landing on column 1.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'd255, 1'b1, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b1, 8'd244, 10'd1, 10'd1},
    '{8'd0,   1'b1, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd0,   1'b0, 1'b1, 8'd0,   10'd1, 10'd1},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd17,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd200, 1'b1, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd99,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
    '{8'd3,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      pix_valid;
  logic                      pix_stall;
  gb3_pkg::in_t              pix_data;
  logic                      res_valid;
  logic                      res_stall;
  gb3_pkg::out_t             res_data;
  logic                      cfg_we;
  logic [gb3_pkg::CFG_W-1:0] cfg_wdata;

  gaussian_blur_3x3_stream u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_valid),
    .in_stall_o  (pix_stall),
    .in_data_i   (pix_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state
  logic [gb3_pkg::PIX_W-1:0] up_line  [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] mid_line [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] win_px   [6];
  int unsigned               pos_col;
  int unsigned               pos_row;
  logic [gb3_pkg::CFG_W-1:0] cur_width;

  gb3_pkg::out_t blur_expected [$];
  int unsigned   blur_errors;
  bit            pix_burst;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned line_span(input logic [gb3_pkg::CFG_W-1:0] w);
    int unsigned s;
    s = w;
    if (s < gb3_pkg::MIN_WIDTH) s = gb3_pkg::MIN_WIDTH;
    if (s > gb3_pkg::MAX_WIDTH) s = gb3_pkg::MAX_WIDTH;
    return s;
  endfunction

  task automatic blur_predict(input gb3_pkg::in_t d, output bit hit,
                              output gb3_pkg::out_t r);
    int unsigned c, rw, up, md, corners, others, span;
    span = line_span(cur_width);
    if (d.frame_start) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= gb3_pkg::MAX_WIDTH) pos_col = 0;
    c   = pos_col;
    rw  = pos_row;
    up  = up_line[c];
    md  = mid_line[c];
    hit = 1'b0;
    r   = '0;
    if (rw >= 2 && c >= 2) begin
      corners   = win_px[0] + win_px[2] + up + d.pixel;
      others    = win_px[1] + win_px[3] + win_px[4] + win_px[5] + md;
      r.blurred = gb3_pkg::PIX_W'((9 * corners + 12 * others) / 100);
      r.out_row = gb3_pkg::ROW_W'(rw - 1);
      r.out_col = gb3_pkg::COL_W'(c - 1);
      hit       = 1'b1;
    end
    win_px[0]   = win_px[3];
    win_px[1]   = win_px[4];
    win_px[2]   = win_px[5];
    win_px[3]   = gb3_pkg::PIX_W'(up);
    win_px[4]   = gb3_pkg::PIX_W'(md);
    win_px[5]   = d.pixel;
    up_line[c]  = gb3_pkg::PIX_W'(md);
    mid_line[c] = d.pixel;
    if (c + 1 >= span) begin
      pos_col = 0;
      if (pos_row < gb3_pkg::MAX_HEIGHT - 1) pos_row = pos_row + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  // Offers one pixel, waits for the transaction, then records what it yields.
  task automatic send_pixel(input gb3_pkg::in_t d, input bit typed,
                            input gb3_pkg::out_t typed_res);
    int unsigned   gap;
    bit            hit;
    gb3_pkg::out_t r;
    if ($urandom_range(0, 39) == 0) pix_burst = !pix_burst;
    gap = pix_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_valid <= 1'b1;
    pix_data  <= d;
    do @(posedge clk_i); while (pix_stall);
    blur_predict(d, hit, r);
    if (typed) blur_expected.push_back(typed_res);
    else if (hit) blur_expected.push_back(r);
  endtask

  task automatic set_width(input logic [gb3_pkg::CFG_W-1:0] w);
    pix_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_width = w;
  endtask

  // First pixel opens a frame; later ones restart it with odds 1/fs_odds.
  task automatic run_frame(input int unsigned n, input int unsigned fs_odds);
    gb3_pkg::in_t d;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) d.pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else d.pixel = gb3_pkg::PIX_W'($urandom_range(0, 255));
      if (k == 0) d.frame_start = 1'b1;
      else if (fs_odds == 0) d.frame_start = 1'b0;
      else d.frame_start = ($urandom_range(0, fs_odds - 1) == 0);
      send_pixel(d, 1'b0, '0);
    end
  endtask

  initial begin : pixel_source
    int unsigned               rand_items, span, n;
    logic [gb3_pkg::CFG_W-1:0] w;
    gb3_pkg::in_t              d;
    gb3_pkg::out_t             t;
    pix_valid   <= 1'b0;
    pix_data    <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    rst_ni      <= 1'b0;
    blur_errors = 0;
    pix_burst   = 1'b0;
    cur_width   = gb3_pkg::LINE_WIDTH_RESET;
    pos_col     = 0;
    pos_row     = 0;
    for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
      up_line[i]  = '0;
      mid_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_px[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Width out of reset is the full 1024: three rows reach column 1022.
    run_frame(3 * gb3_pkg::MAX_WIDTH, 0);

    set_width(gb3_pkg::CFG_W'(3));
    for (int i = 0; i < DIR_N; i++) begin
      d.pixel       = DIR_TAB[i].pixel;
      d.frame_start = DIR_TAB[i].fs;
      t.blurred     = DIR_TAB[i].blurred;
      t.out_row     = DIR_TAB[i].row;
      t.out_col     = DIR_TAB[i].col;
      send_pixel(d, DIR_TAB[i].typed, t);
    end

    // Out-of-range widths clamp to the legal span
    set_width(gb3_pkg::CFG_W'(0));
    run_frame(14, 0);
    set_width({gb3_pkg::CFG_W{1'b1}});
    run_frame(2 * gb3_pkg::MAX_WIDTH + 10, 0);

    // Tall frame: row counter saturates, out_row sticks at MAX_HEIGHT-2
    set_width(gb3_pkg::CFG_W'(2));
    run_frame(3 * (gb3_pkg::MAX_HEIGHT + 6), 0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = gb3_pkg::CFG_W'($urandom_range(0, 2));
        1:       w = gb3_pkg::CFG_W'($urandom_range(25, 64));
        default: w = gb3_pkg::CFG_W'($urandom_range(3, 24));
      endcase
      set_width(w);
      span = line_span(w);
      n    = span * $urandom_range(3, 6) + $urandom_range(0, span - 1);
      run_frame(n, ($urandom_range(0, 7) == 0) ? 4 : 60);
      rand_items += n;
    end

    pix_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (blur_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned   hold, got;
    bit            calm;
    gb3_pkg::out_t want;
    got  = 0;
    calm = 1'b0;
    res_stall <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      // one long hold-off lets the block back up into its input
      if (got == HOLD_AT) hold = HOLD_LEN;
      else hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      res_stall <= 1'b0;
      do @(posedge clk_i); while (!res_valid);
      got++;
      if (blur_expected.size() == 0) begin
        $error("unexpected result: blurred %0d row %0d col %0d",
               res_data.blurred, res_data.out_row, res_data.out_col);
        blur_errors++;
      end else begin
        want = blur_expected.pop_front();
        if (res_data.blurred !== want.blurred) begin
          $error("blurred: expected %0d, actual %0d", want.blurred, res_data.blurred);
          blur_errors++;
        end
        if (res_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, actual %0d", want.out_row, res_data.out_row);
          blur_errors++;
        end
        if (res_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, actual %0d", want.out_col, res_data.out_col);
          blur_errors++;
        end
      end
    end
  end

endmodule

### filelist.f
src/gb3_pkg.sv
src/gb3_line_store.sv
src/gb3_kernel.sv
src/gaussian_blur_3x3_stream.sv
src/gb3_checker.sv
tb/sv/testbench.sv
